@@ src/mer_pkg.sv @@
package mer_pkg;

    // Field widths
    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;
    localparam int OUT_W       = COORD_BITS + 1;      // mirrored coordinate
    localparam int OFF_W       = RADIUS_BITS + 1;     // x / y offset
    localparam int SQ_W        = 2 * RADIUS_BITS;     // radius squared
    localparam int STEP_W      = SQ_W + OFF_W + 1;    // 2*r^2*offset
    localparam int HX_W        = OFF_W + 1;           // 2*x+1
    localparam int MUL_W       = 2 * HX_W;            // multiplier operand
    localparam int PROD_W      = 2 * MUL_W;           // multiplier product
    localparam int DEC_W       = 2 * SQ_W + 8;        // decision value

    localparam int S_TDATA_W   = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((4 * OUT_W + 7) / 8) * 8;

    // tdata field offsets, input side
    localparam int S_CX_LSB    = 0;
    localparam int S_CY_LSB    = COORD_BITS;
    localparam int S_RX_LSB    = 2 * COORD_BITS;
    localparam int S_RY_LSB    = 2 * COORD_BITS + RADIUS_BITS;

    // Request kinds carried on s_tuser
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SA,
        ST_SB,
        ST_SC,
        ST_SD,
        ST_R1,
        ST_XA,
        ST_XB,
        ST_XC,
        ST_XD,
        ST_XE,
        ST_XF,
        ST_R2,
        ST_EMIT,
        ST_NULL
    } state_t;

    // Operand pairs for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RXSQ_RY,
        MUL_HX_HX,
        MUL_RYSQ_PROD,
        MUL_YM_YM,
        MUL_RXSQ_PROD,
        MUL_RXSQ_RYSQ
    } mul_op_t;

    // Register update selects
    typedef enum logic [3:0] {
        UPD_NONE,
        UPD_RXSQ,
        UPD_RYSQ,
        UPD_SETUP,
        UPD_R1,
        UPD_R2,
        UPD_DEC_LOAD,
        UPD_DEC_ADD4,
        UPD_DEC_SUB4,
        UPD_EMIT,
        UPD_EMIT_NULL
    } upd_op_t;

    typedef struct packed {
        logic    latch_in;
        mul_op_t mul_op;
        upd_op_t upd_op;
    } dp_cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   r1_go;      // region 1 continues: step_x < step_y
        logic   out_free;   // output register can take a result
    } dp_status_t;

endpackage

@@ src/mer_ctrl.sv @@
module mer_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_req,
    output logic                 s_tready,
    input  mer_pkg::dp_status_t  status,
    output mer_pkg::dp_cmd_t     cmd
);

    mer_pkg::state_t state_reg;
    mer_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mer_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.latch_in = 1'b0;
        cmd.mul_op   = mer_pkg::MUL_NONE;
        cmd.upd_op   = mer_pkg::UPD_NONE;
        case (state_reg)
            mer_pkg::ST_IDLE: begin
                // no transfer is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    if (s_req == mer_pkg::REQ_START) begin
                        cmd.latch_in = 1'b1;
                        state_next   = mer_pkg::ST_SA;
                    end else begin
                        case (status.phase)
                            mer_pkg::PH_R1: state_next = status.r1_go ? mer_pkg::ST_R1
                                                                      : mer_pkg::ST_XA;
                            mer_pkg::PH_R2: state_next = mer_pkg::ST_R2;
                            default:        state_next = mer_pkg::ST_NULL;
                        endcase
                    end
                end
            end
            // start: rx^2, ry^2, rx^2*ry, then setup
            mer_pkg::ST_SA: begin
                cmd.mul_op = mer_pkg::MUL_RX_RX;
                state_next = mer_pkg::ST_SB;
            end
            mer_pkg::ST_SB: begin
                cmd.upd_op = mer_pkg::UPD_RXSQ;
                cmd.mul_op = mer_pkg::MUL_RY_RY;
                state_next = mer_pkg::ST_SC;
            end
            mer_pkg::ST_SC: begin
                cmd.upd_op = mer_pkg::UPD_RYSQ;
                cmd.mul_op = mer_pkg::MUL_RXSQ_RY;
                state_next = mer_pkg::ST_SD;
            end
            mer_pkg::ST_SD: begin
                cmd.upd_op = mer_pkg::UPD_SETUP;
                state_next = mer_pkg::ST_EMIT;
            end
            mer_pkg::ST_R1: begin
                cmd.upd_op = mer_pkg::UPD_R1;
                state_next = mer_pkg::ST_EMIT;
            end
            // crossover: ry^2*hx^2 + 4*rx^2*ym^2 - 4*rx^2*ry^2
            mer_pkg::ST_XA: begin
                cmd.mul_op = mer_pkg::MUL_HX_HX;
                state_next = mer_pkg::ST_XB;
            end
            mer_pkg::ST_XB: begin
                cmd.mul_op = mer_pkg::MUL_RYSQ_PROD;
                state_next = mer_pkg::ST_XC;
            end
            mer_pkg::ST_XC: begin
                cmd.upd_op = mer_pkg::UPD_DEC_LOAD;
                cmd.mul_op = mer_pkg::MUL_YM_YM;
                state_next = mer_pkg::ST_XD;
            end
            mer_pkg::ST_XD: begin
                cmd.mul_op = mer_pkg::MUL_RXSQ_PROD;
                state_next = mer_pkg::ST_XE;
            end
            mer_pkg::ST_XE: begin
                cmd.upd_op = mer_pkg::UPD_DEC_ADD4;
                cmd.mul_op = mer_pkg::MUL_RXSQ_RYSQ;
                state_next = mer_pkg::ST_XF;
            end
            mer_pkg::ST_XF: begin
                cmd.upd_op = mer_pkg::UPD_DEC_SUB4;
                state_next = mer_pkg::ST_R2;
            end
            mer_pkg::ST_R2: begin
                cmd.upd_op = mer_pkg::UPD_R2;
                state_next = mer_pkg::ST_EMIT;
            end
            mer_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.upd_op = mer_pkg::UPD_EMIT;
                    state_next = mer_pkg::ST_IDLE;
                end
            end
            mer_pkg::ST_NULL: begin
                if (status.out_free) begin
                    cmd.upd_op = mer_pkg::UPD_EMIT_NULL;
                    state_next = mer_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mer_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/mer_datapath.sv @@
module mer_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  mer_pkg::dp_cmd_t                       cmd,
    output mer_pkg::dp_status_t                    status,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  center_x,
    input  logic signed [mer_pkg::COORD_BITS-1:0]  center_y,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] radius_x,
    input  logic        [mer_pkg::RADIUS_BITS-1:0] radius_y,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic                                   point_valid,
    output logic                                   last_point,
    output logic signed [mer_pkg::OUT_W-1:0]       x_right,
    output logic signed [mer_pkg::OUT_W-1:0]       x_left,
    output logic signed [mer_pkg::OUT_W-1:0]       y_lower,
    output logic signed [mer_pkg::OUT_W-1:0]       y_upper
);

    localparam int DW = mer_pkg::DEC_W;
    localparam int SW = mer_pkg::STEP_W;

    mer_pkg::phase_t                       phase_reg;
    logic                                  m_valid_reg;
    logic        [mer_pkg::OFF_W-1:0]      ox_reg;
    logic        [mer_pkg::OFF_W-1:0]      oy_reg;
    logic        [SW-1:0]                  stx_reg;
    logic        [SW-1:0]                  sty_reg;
    logic signed [DW-1:0]                  dec_reg;
    logic signed [mer_pkg::COORD_BITS-1:0] lcx_reg;
    logic signed [mer_pkg::COORD_BITS-1:0] lcy_reg;
    logic        [mer_pkg::RADIUS_BITS-1:0] rx_reg;
    logic        [mer_pkg::RADIUS_BITS-1:0] ry_reg;
    logic        [mer_pkg::SQ_W-1:0]       rxsq_reg;
    logic        [mer_pkg::SQ_W-1:0]       rysq_reg;
    logic        [mer_pkg::PROD_W-1:0]     prod_reg;
    logic                                  last_reg;
    logic                                  pv_reg;
    logic signed [mer_pkg::OUT_W-1:0]      xr_reg;
    logic signed [mer_pkg::OUT_W-1:0]      xl_reg;
    logic signed [mer_pkg::OUT_W-1:0]      yl_reg;
    logic signed [mer_pkg::OUT_W-1:0]      yu_reg;

    logic [mer_pkg::MUL_W-1:0] mul_a;
    logic [mer_pkg::MUL_W-1:0] mul_b;
    logic [mer_pkg::HX_W-1:0]  hx;
    logic [mer_pkg::OFF_W-1:0] ym;
    logic [SW-1:0]             stx_inc;
    logic [SW-1:0]             sty_dec;
    logic signed [DW-1:0]      rxsq_d;
    logic signed [DW-1:0]      rysq_d;
    logic signed [DW-1:0]      stx_inc_d;
    logic signed [DW-1:0]      sty_dec_d;
    logic signed [DW-1:0]      prod_d;
    logic signed [DW-1:0]      dec_r1;
    logic signed [DW-1:0]      dec_r2;
    logic signed [mer_pkg::OUT_W-1:0] cx_w;
    logic signed [mer_pkg::OUT_W-1:0] cy_w;
    logic signed [mer_pkg::OUT_W-1:0] ox_w;
    logic signed [mer_pkg::OUT_W-1:0] oy_w;

    assign hx = {ox_reg, 1'b1};
    assign ym = oy_reg - mer_pkg::OFF_W'(1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            mer_pkg::MUL_RX_RX: begin
                mul_a = mer_pkg::MUL_W'(rx_reg);
                mul_b = mer_pkg::MUL_W'(rx_reg);
            end
            mer_pkg::MUL_RY_RY: begin
                mul_a = mer_pkg::MUL_W'(ry_reg);
                mul_b = mer_pkg::MUL_W'(ry_reg);
            end
            mer_pkg::MUL_RXSQ_RY: begin
                mul_a = mer_pkg::MUL_W'(rxsq_reg);
                mul_b = mer_pkg::MUL_W'(ry_reg);
            end
            mer_pkg::MUL_HX_HX: begin
                mul_a = mer_pkg::MUL_W'(hx);
                mul_b = mer_pkg::MUL_W'(hx);
            end
            mer_pkg::MUL_RYSQ_PROD: begin
                mul_a = mer_pkg::MUL_W'(rysq_reg);
                mul_b = prod_reg[mer_pkg::MUL_W-1:0];
            end
            mer_pkg::MUL_YM_YM: begin
                mul_a = mer_pkg::MUL_W'(ym);
                mul_b = mer_pkg::MUL_W'(ym);
            end
            mer_pkg::MUL_RXSQ_PROD: begin
                mul_a = mer_pkg::MUL_W'(rxsq_reg);
                mul_b = prod_reg[mer_pkg::MUL_W-1:0];
            end
            mer_pkg::MUL_RXSQ_RYSQ: begin
                mul_a = mer_pkg::MUL_W'(rxsq_reg);
                mul_b = mer_pkg::MUL_W'(rysq_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // step terms move by 2*r^2
    assign stx_inc   = stx_reg + SW'({rysq_reg, 1'b0});
    assign sty_dec   = sty_reg - SW'({rxsq_reg, 1'b0});
    assign rxsq_d    = signed'(DW'(rxsq_reg));
    assign rysq_d    = signed'(DW'(rysq_reg));
    assign stx_inc_d = signed'(DW'(stx_inc));
    assign sty_dec_d = signed'(DW'(sty_dec));
    assign prod_d    = signed'(DW'(prod_reg));

    always_comb begin
        if (dec_reg < 0) begin
            dec_r1 = dec_reg + rysq_d + stx_inc_d;
        end else begin
            dec_r1 = dec_reg + rysq_d + stx_inc_d - sty_dec_d;
        end
        if (dec_reg > 0) begin
            dec_r2 = dec_reg + ((rxsq_d - sty_dec_d) <<< 2);
        end else begin
            dec_r2 = dec_reg + ((rxsq_d - sty_dec_d + stx_inc_d) <<< 2);
        end
    end

    // centers sign-extend and offsets zero-extend to the output width
    assign cx_w = mer_pkg::OUT_W'(lcx_reg);
    assign cy_w = mer_pkg::OUT_W'(lcy_reg);
    assign ox_w = signed'(mer_pkg::OUT_W'(ox_reg));
    assign oy_w = signed'(mer_pkg::OUT_W'(oy_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= mer_pkg::PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (cmd.upd_op)
                mer_pkg::UPD_SETUP:    phase_reg <= mer_pkg::PH_R1;
                mer_pkg::UPD_DEC_SUB4: phase_reg <= mer_pkg::PH_R2;
                mer_pkg::UPD_EMIT: begin
                    if (oy_reg == '0) begin
                        phase_reg <= mer_pkg::PH_IDLE;
                    end
                end
                default: ;
            endcase
            // a new result may replace one leaving in the same cycle
            if (cmd.upd_op inside {mer_pkg::UPD_EMIT, mer_pkg::UPD_EMIT_NULL}) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            lcx_reg <= center_x;
            lcy_reg <= center_y;
            rx_reg  <= radius_x;
            ry_reg  <= radius_y;
        end
        if (cmd.mul_op != mer_pkg::MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.upd_op)
            mer_pkg::UPD_RXSQ: rxsq_reg <= prod_reg[mer_pkg::SQ_W-1:0];
            mer_pkg::UPD_RYSQ: rysq_reg <= prod_reg[mer_pkg::SQ_W-1:0];
            mer_pkg::UPD_SETUP: begin
                // prod holds rx^2*ry
                ox_reg  <= '0;
                oy_reg  <= mer_pkg::OFF_W'(ry_reg);
                stx_reg <= '0;
                sty_reg <= {prod_reg[SW-2:0], 1'b0};
                dec_reg <= rysq_d - prod_d + signed'(DW'(rxsq_reg >> 2));
            end
            mer_pkg::UPD_R1: begin
                ox_reg  <= ox_reg + mer_pkg::OFF_W'(1);
                stx_reg <= stx_inc;
                dec_reg <= dec_r1;
                if (dec_reg >= 0) begin
                    oy_reg  <= oy_reg - mer_pkg::OFF_W'(1);
                    sty_reg <= sty_dec;
                end
            end
            mer_pkg::UPD_R2: begin
                oy_reg  <= oy_reg - mer_pkg::OFF_W'(1);
                sty_reg <= sty_dec;
                dec_reg <= dec_r2;
                if (dec_reg <= 0) begin
                    ox_reg  <= ox_reg + mer_pkg::OFF_W'(1);
                    stx_reg <= stx_inc;
                end
            end
            mer_pkg::UPD_DEC_LOAD: dec_reg <= prod_d;
            mer_pkg::UPD_DEC_ADD4: dec_reg <= dec_reg + (prod_d <<< 2);
            mer_pkg::UPD_DEC_SUB4: dec_reg <= dec_reg - (prod_d <<< 2);
            mer_pkg::UPD_EMIT: begin
                pv_reg   <= 1'b1;
                last_reg <= (oy_reg == '0);
                xr_reg   <= cx_w + ox_w;
                xl_reg   <= cx_w - ox_w;
                yl_reg   <= cy_w + oy_w;
                yu_reg   <= cy_w - oy_w;
            end
            mer_pkg::UPD_EMIT_NULL: begin
                pv_reg   <= 1'b0;
                last_reg <= 1'b0;
                xr_reg   <= '0;
                xl_reg   <= '0;
                yl_reg   <= '0;
                yu_reg   <= '0;
            end
            default: ;
        endcase
    end

    assign status.phase    = phase_reg;
    assign status.r1_go    = (stx_reg < sty_reg);
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid    = m_valid_reg;
    assign point_valid = pv_reg;
    assign last_point  = last_reg;
    assign x_right     = xr_reg;
    assign x_left      = xl_reg;
    assign y_lower     = yl_reg;
    assign y_upper     = yu_reg;

endmodule

@@ src/midpoint_ellipse_rasterizer.sv @@
// Midpoint ellipse rasterizer: one ellipse point per input transfer.
// Input stream (s_*): s_tuser = request kind (0 start, 1 step); s_tdata carries
//   center_x, center_y, radius_x, radius_y, used only on a start transfer.
// Output stream (m_*): one result per input transfer. m_tuser = point_valid,
//   m_tlast = last_point (y offset reached 0), m_tdata = four mirrored coords.
//   A step transfer with no ellipse running returns point_valid=0, all zeros.
// Sequence after accept: a start runs SA to SD, then EMIT; a region step runs
//   R1 or R2, then EMIT; the step that crosses into region 2 runs XA to XF, R2,
//   then EMIT (five passes through the shared multiplier to form the scaled
//   region-2 decision value). One item at a time: no new transfer is taken
//   until the sequencer, which drives the single registered multiplier, is
//   idle again, after EMIT has placed the result in the output register.
// s_tready is high only while the sequencer waits for work; a transfer is taken
//   even while the previous result still sits unclaimed in the output register.
// Receiver stall: the result register holds; the next result waits in the
//   sequencer until m_tready frees the register, so nothing is lost or repeated.
// Reset (aresetn low, synchronous): sequencer idle, no ellipse running, output
//   register empty. No clearing pass is needed.
module midpoint_ellipse_rasterizer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [11:0] center_x, [23:12] center_y, [33:24] radius_x, [43:34] radius_y
    input  logic [mer_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [12:0] x_right, [25:13] x_left, [38:26] y_lower, [51:39] y_upper
    output logic [mer_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] point_valid
    output logic                           m_tuser,
    output logic                           m_tlast
);

    mer_pkg::dp_cmd_t    cmd;
    mer_pkg::dp_status_t status;

    logic signed [mer_pkg::OUT_W-1:0] x_right;
    logic signed [mer_pkg::OUT_W-1:0] x_left;
    logic signed [mer_pkg::OUT_W-1:0] y_lower;
    logic signed [mer_pkg::OUT_W-1:0] y_upper;

    // sequencer: decodes the request and walks setup / step / crossover
    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_req    (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // state registers, shared multiplier, decision updates, result register
    mer_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .center_x    (s_tdata[mer_pkg::S_CX_LSB +: mer_pkg::COORD_BITS]),
        .center_y    (s_tdata[mer_pkg::S_CY_LSB +: mer_pkg::COORD_BITS]),
        .radius_x    (s_tdata[mer_pkg::S_RX_LSB +: mer_pkg::RADIUS_BITS]),
        .radius_y    (s_tdata[mer_pkg::S_RY_LSB +: mer_pkg::RADIUS_BITS]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .point_valid (m_tuser),
        .last_point  (m_tlast),
        .x_right     (x_right),
        .x_left      (x_left),
        .y_lower     (y_lower),
        .y_upper     (y_upper)
    );

    // pack coordinates, zero fill to whole bytes
    assign m_tdata = mer_pkg::M_TDATA_W'({y_upper, y_lower, x_left, x_right});

endmodule

@@ src/mer_checker.sv @@
module mer_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mer_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mer_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one item at a time: ready drops after each input transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken back to back");

    // the last point is always a real point
    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last flag on an empty result");

    // an empty result carries no coordinates
    a_null_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0 && !m_tlast)
        else $error("empty result with data");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);
